>>> design/bfa_pkg.sv
// ---------------------------------------------------------------------------
// bfa_pkg: shared definitions for the bitmap frame allocator
// Request codes, status codes, register indexes and the map command bundle.
// ---------------------------------------------------------------------------
package bfa_pkg;

  localparam int ADDR_W = 48;

  localparam logic [1:0] REQ_ALLOC = 2'd0;
  localparam logic [1:0] REQ_FREE  = 2'd1;
  localparam logic [1:0] REQ_INIT  = 2'd2;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_OOM     = 2'd1;
  localparam logic [1:0] ST_BELOW   = 2'd2;
  localparam logic [1:0] ST_INVALID = 2'd3;

  localparam logic CFG_BASE = 1'b0;
  localparam logic CFG_MEM  = 1'b1;

  // Command bundle from the request engine to the used-bit map.
  typedef struct packed {
    logic rd;
    logic wr;
    logic clear;
  } map_cmd_t;

endpackage

>>> design/bitmap_frame_allocator.sv
// ---------------------------------------------------------------------------
// bitmap_frame_allocator: first-fit page frame allocator
// One used bit per page frame, kept in a map memory of MAX_FRAME_COUNT /
// WORD_BITS words. Init takes base_address and memory_bytes / PAGE_BYTES
// (capped at MAX_FRAME_COUNT) and empties the map without a clearing pass,
// since a fill count marks the rows in use; no clearing pass follows reset
// either. Alloc reads one map word per cycle from frame zero up to the first
// free frame, at most MAP_WORDS words (1024 by default); with a frame count
// of zero it answers out of memory without reading the map. Free is refused
// without a map read when the address lies below the base or past the frame
// count. Init and the unused request code read no map word. While a stalled
// output holds the previous result, a finished request waits in the engine.
// One request is worked on at a time; a finished result sits in the output
// register while the next request is taken. PAGE_BYTES and WORD_BITS are
// powers of two.
// ---------------------------------------------------------------------------
module bitmap_frame_allocator
  import bfa_pkg::*;
#(
  parameter int MAX_FRAME_COUNT = 65536,
  parameter int WORD_BITS       = 64,
  parameter int PAGE_BYTES      = 4096
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_we,
  input  logic                                 cfg_index,
  input  logic [ADDR_W-1:0]                    cfg_wdata,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [1:0]                           in_req_type,
  input  logic [ADDR_W-1:0]                    in_free_address,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [1:0]                           out_status,
  output logic [ADDR_W-1:0]                    out_frame_address,
  output logic [$clog2(MAX_FRAME_COUNT+1)-1:0] out_free_count
);

  localparam int MAP_WORDS = (MAX_FRAME_COUNT + WORD_BITS - 1) / WORD_BITS;
  localparam int WADDR_W   = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int FCNT_W    = $clog2(MAX_FRAME_COUNT + 1);

  logic [ADDR_W-1:0]    base_r, base_nxt;
  logic [ADDR_W-1:0]    mem_bytes_r, mem_bytes_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [1:0]           out_status_r;
  logic [ADDR_W-1:0]    out_addr_r;
  logic [FCNT_W-1:0]    out_count_r;

  logic                 eng_idle;
  logic                 req_go;
  logic                 res_valid;
  logic                 res_ready;
  logic [1:0]           res_status;
  logic [ADDR_W-1:0]    res_addr;
  logic [FCNT_W-1:0]    res_count;
  map_cmd_t             map_cmd;
  logic [WADDR_W-1:0]   map_rd_addr;
  logic [WADDR_W-1:0]   map_wr_addr;
  logic [WORD_BITS-1:0] map_wr_data;
  logic [WORD_BITS-1:0] map_rd_data;

  always_comb begin
    base_nxt      = base_r;
    mem_bytes_nxt = mem_bytes_r;
    if (cfg_we) begin
      case (cfg_index)
        CFG_BASE: base_nxt      = cfg_wdata;
        CFG_MEM:  mem_bytes_nxt = cfg_wdata;
        default:  ;
      endcase
    end
  end

  assign in_stall  = !eng_idle;
  assign req_go    = in_valid && eng_idle;
  assign res_ready = !out_valid_r || !out_stall;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res_valid && res_ready) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r      <= '0;
      mem_bytes_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      base_r      <= base_nxt;
      mem_bytes_r <= mem_bytes_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_status_r <= res_status;
      out_addr_r   <= res_addr;
      out_count_r  <= res_count;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_frame_address = out_addr_r;
  assign out_free_count    = out_count_r;

  bfa_engine #(
    .MAX_FRAME_COUNT (MAX_FRAME_COUNT),
    .WORD_BITS       (WORD_BITS),
    .PAGE_BYTES      (PAGE_BYTES),
    .WADDR_W         (WADDR_W),
    .FCNT_W          (FCNT_W)
  ) u_engine (
    .clk           (clk),
    .rst_n         (rst_n),
    .req_go        (req_go),
    .req_type      (in_req_type),
    .free_address  (in_free_address),
    .cfg_base      (base_r),
    .cfg_mem_bytes (mem_bytes_r),
    .idle          (eng_idle),
    .res_valid     (res_valid),
    .res_ready     (res_ready),
    .res_status    (res_status),
    .res_addr      (res_addr),
    .res_count     (res_count),
    .map_cmd       (map_cmd),
    .map_rd_addr   (map_rd_addr),
    .map_wr_addr   (map_wr_addr),
    .map_wr_data   (map_wr_data),
    .map_rd_data   (map_rd_data)
  );

  bfa_map #(
    .WORDS   (MAP_WORDS),
    .WORD_W  (WORD_BITS),
    .WADDR_W (WADDR_W)
  ) u_map (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (map_cmd),
    .rd_addr (map_rd_addr),
    .wr_addr (map_wr_addr),
    .wr_data (map_wr_data),
    .rd_data (map_rd_data)
  );

endmodule

>>> design/bfa_map.sv
// ---------------------------------------------------------------------------
// bfa_map: used-bit map storage
// One word of used bits per row in a synchronous memory with a registered
// read. A fill count marks the rows written since the last clear; rows at or
// above it read as all free.
// ---------------------------------------------------------------------------
module bfa_map
  import bfa_pkg::*;
#(
  parameter int WORDS   = 1024,
  parameter int WORD_W  = 64,
  parameter int WADDR_W = 10
) (
  input  logic               clk,
  input  logic               rst_n,
  input  map_cmd_t           cmd,
  input  logic [WADDR_W-1:0] rd_addr,
  input  logic [WADDR_W-1:0] wr_addr,
  input  logic [WORD_W-1:0]  wr_data,
  output logic [WORD_W-1:0]  rd_data
);

  localparam int HWM_W = $clog2(WORDS + 1);

  logic [WORD_W-1:0] mem [WORDS];
  logic [WORD_W-1:0] mem_q_r;
  logic              zero_q_r;
  logic [HWM_W-1:0]  hwm_r;
  logic [HWM_W-1:0]  hwm_nxt;

  always_ff @(posedge clk) begin
    if (cmd.wr) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd.rd) begin
      mem_q_r <= mem[rd_addr];
    end
  end

  // A row is only ever written once every row below it has been written, so
  // the count grows by at most one.
  always_comb begin
    hwm_nxt = hwm_r;
    if (cmd.clear) begin
      hwm_nxt = '0;
    end else if (cmd.wr && (HWM_W'(wr_addr) >= hwm_r)) begin
      hwm_nxt = HWM_W'(wr_addr) + HWM_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hwm_r    <= '0;
      zero_q_r <= 1'b1;
    end else begin
      hwm_r <= hwm_nxt;
      if (cmd.rd) begin
        zero_q_r <= (HWM_W'(rd_addr) >= hwm_r);
      end
    end
  end

  assign rd_data = zero_q_r ? '0 : mem_q_r;

  a_fill_grows_by_one: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.wr |-> (HWM_W'(wr_addr) <= hwm_r))
    else $error("map write skips past the fill count");

  a_clear_alone: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.clear |-> !(cmd.rd || cmd.wr))
    else $error("map clear overlaps an access");

  a_no_same_row: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.rd && cmd.wr) |-> (rd_addr != wr_addr))
    else $error("map read and write of the same row in one cycle");

endmodule

>>> design/bfa_engine.sv
// ---------------------------------------------------------------------------
// bfa_engine: request sequencer
// Runs alloc, free and init requests against the used-bit map with
// read-modify-write and holds the allocator's live base, frame count and
// free counter.
// ---------------------------------------------------------------------------
module bfa_engine
  import bfa_pkg::*;
#(
  parameter int MAX_FRAME_COUNT = 65536,
  parameter int WORD_BITS       = 64,
  parameter int PAGE_BYTES      = 4096,
  parameter int WADDR_W         = 10,
  parameter int FCNT_W          = 17
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               req_go,
  input  logic [1:0]         req_type,
  input  logic [ADDR_W-1:0]  free_address,
  input  logic [ADDR_W-1:0]  cfg_base,
  input  logic [ADDR_W-1:0]  cfg_mem_bytes,
  output logic               idle,
  output logic               res_valid,
  input  logic               res_ready,
  output logic [1:0]         res_status,
  output logic [ADDR_W-1:0]  res_addr,
  output logic [FCNT_W-1:0]  res_count,
  output map_cmd_t           map_cmd,
  output logic [WADDR_W-1:0] map_rd_addr,
  output logic [WADDR_W-1:0] map_wr_addr,
  output logic [WORD_BITS-1:0] map_wr_data,
  input  logic [WORD_BITS-1:0] map_rd_data
);

  localparam int MAP_WORDS  = (MAX_FRAME_COUNT + WORD_BITS - 1) / WORD_BITS;
  localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);
  localparam int BIT_W      = $clog2(WORD_BITS);
  localparam int IDX_W      = ADDR_W - PAGE_SHIFT;
  localparam int FB_W       = $clog2(MAP_WORDS * WORD_BITS + 1);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_SCAN = 6'b000010,
    S_ADDR = 6'b000100,
    S_FCHK = 6'b001000,
    S_FRD  = 6'b010000,
    S_DONE = 6'b100000
  } state_t;

  state_t              state_r, state_nxt;
  logic [ADDR_W-1:0]   live_base_r, live_base_nxt;
  logic [FCNT_W-1:0]   live_frames_r, live_frames_nxt;
  logic [FCNT_W-1:0]   free_cnt_r, free_cnt_nxt;
  logic [WADDR_W-1:0]  cur_word_r, cur_word_nxt;
  logic [FB_W-1:0]     frame_base_r, frame_base_nxt;
  logic [FB_W-1:0]     alloc_idx_r, alloc_idx_nxt;
  logic [ADDR_W-1:0]   fr_addr_r, fr_addr_nxt;
  logic [WADDR_W-1:0]  fr_word_r, fr_word_nxt;
  logic [BIT_W-1:0]    fr_bit_r, fr_bit_nxt;
  logic [1:0]          res_status_r, res_status_nxt;
  logic [ADDR_W-1:0]   res_addr_r, res_addr_nxt;

  logic                zero_found;
  logic [BIT_W-1:0]    zero_bit;
  logic [FB_W-1:0]     cand_idx;
  logic [FB_W-1:0]     next_base;
  logic                scan_hit;
  logic                scan_more;
  logic [WORD_BITS-1:0] set_mask;
  logic [WORD_BITS-1:0] clr_mask;
  logic [ADDR_W:0]     diff;
  logic [IDX_W-1:0]    fidx;
  logic [IDX_W-1:0]    mem_frames;
  logic [FCNT_W-1:0]   frames_cap;

  // Lowest clear bit of the map word that came back from memory.
  always_comb begin
    zero_found = 1'b0;
    zero_bit   = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (!map_rd_data[i]) begin
        zero_found = 1'b1;
        zero_bit   = BIT_W'(i);
      end
    end
  end

  assign cand_idx  = frame_base_r + FB_W'(zero_bit);
  assign next_base = frame_base_r + FB_W'(WORD_BITS);
  assign scan_hit  = zero_found && (cand_idx < FB_W'(live_frames_r));
  assign scan_more = !zero_found && (next_base < FB_W'(live_frames_r));
  assign set_mask  = {{(WORD_BITS-1){1'b0}}, 1'b1} << zero_bit;
  assign clr_mask  = ~({{(WORD_BITS-1){1'b0}}, 1'b1} << fr_bit_r);

  assign diff       = {1'b0, fr_addr_r} - {1'b0, live_base_r};
  assign fidx       = diff[ADDR_W-1:PAGE_SHIFT];
  assign mem_frames = cfg_mem_bytes[ADDR_W-1:PAGE_SHIFT];
  assign frames_cap = (mem_frames > IDX_W'(MAX_FRAME_COUNT)) ?
                      FCNT_W'(MAX_FRAME_COUNT) : mem_frames[FCNT_W-1:0];

  always_comb begin
    state_nxt       = state_r;
    live_base_nxt   = live_base_r;
    live_frames_nxt = live_frames_r;
    free_cnt_nxt    = free_cnt_r;
    cur_word_nxt    = cur_word_r;
    frame_base_nxt  = frame_base_r;
    alloc_idx_nxt   = alloc_idx_r;
    fr_addr_nxt     = fr_addr_r;
    fr_word_nxt     = fr_word_r;
    fr_bit_nxt      = fr_bit_r;
    res_status_nxt  = res_status_r;
    res_addr_nxt    = res_addr_r;
    map_cmd         = '0;
    map_rd_addr     = cur_word_r + WADDR_W'(1);
    map_wr_addr     = cur_word_r;
    map_wr_data     = map_rd_data | set_mask;

    case (state_r)
      S_IDLE: begin
        if (req_go) begin
          res_status_nxt = ST_OK;
          res_addr_nxt   = '0;
          case (req_type)
            REQ_ALLOC: begin
              if (live_frames_r == '0) begin
                res_status_nxt = ST_OOM;
                state_nxt      = S_DONE;
              end else begin
                map_cmd.rd     = 1'b1;
                map_rd_addr    = '0;
                cur_word_nxt   = '0;
                frame_base_nxt = '0;
                state_nxt      = S_SCAN;
              end
            end
            REQ_FREE: begin
              fr_addr_nxt = free_address;
              state_nxt   = S_FCHK;
            end
            REQ_INIT: begin
              live_base_nxt   = cfg_base;
              live_frames_nxt = frames_cap;
              free_cnt_nxt    = frames_cap;
              map_cmd.clear   = 1'b1;
              state_nxt       = S_DONE;
            end
            default: begin
              state_nxt = S_DONE;
            end
          endcase
        end
      end
      S_SCAN: begin
        // One map word per cycle; the next row is read while this one is
        // examined.
        if (scan_hit) begin
          map_cmd.wr    = 1'b1;
          free_cnt_nxt  = free_cnt_r - FCNT_W'(1);
          alloc_idx_nxt = cand_idx;
          state_nxt     = S_ADDR;
        end else if (scan_more) begin
          map_cmd.rd     = 1'b1;
          cur_word_nxt   = cur_word_r + WADDR_W'(1);
          frame_base_nxt = next_base;
        end else begin
          res_status_nxt = ST_OOM;
          state_nxt      = S_DONE;
        end
      end
      S_ADDR: begin
        res_addr_nxt = live_base_r + (ADDR_W'(alloc_idx_r) << PAGE_SHIFT);
        state_nxt    = S_DONE;
      end
      S_FCHK: begin
        if (diff[ADDR_W]) begin
          res_status_nxt = ST_BELOW;
          state_nxt      = S_DONE;
        end else if (fidx >= IDX_W'(live_frames_r)) begin
          res_status_nxt = ST_INVALID;
          state_nxt      = S_DONE;
        end else begin
          map_cmd.rd  = 1'b1;
          map_rd_addr = fidx[BIT_W +: WADDR_W];
          fr_word_nxt = fidx[BIT_W +: WADDR_W];
          fr_bit_nxt  = fidx[BIT_W-1:0];
          state_nxt   = S_FRD;
        end
      end
      S_FRD: begin
        if (map_rd_data[fr_bit_r]) begin
          map_cmd.wr   = 1'b1;
          map_wr_addr  = fr_word_r;
          map_wr_data  = map_rd_data & clr_mask;
          free_cnt_nxt = free_cnt_r + FCNT_W'(1);
        end else begin
          res_status_nxt = ST_INVALID;
        end
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      live_base_r   <= '0;
      live_frames_r <= '0;
      free_cnt_r    <= '0;
    end else begin
      state_r       <= state_nxt;
      live_base_r   <= live_base_nxt;
      live_frames_r <= live_frames_nxt;
      free_cnt_r    <= free_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_word_r   <= cur_word_nxt;
    frame_base_r <= frame_base_nxt;
    alloc_idx_r  <= alloc_idx_nxt;
    fr_addr_r    <= fr_addr_nxt;
    fr_word_r    <= fr_word_nxt;
    fr_bit_r     <= fr_bit_nxt;
    res_status_r <= res_status_nxt;
    res_addr_r   <= res_addr_nxt;
  end

  assign idle       = (state_r == S_IDLE);
  assign res_valid  = (state_r == S_DONE);
  assign res_status = res_status_r;
  assign res_addr   = res_addr_r;
  assign res_count  = free_cnt_r;

endmodule

>>> tb/bitmap_frame_allocator_tb.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// bitmap_frame_allocator_tb: self-checking bench for the first-fit allocator
// A short table of corner cases comes first. Random phases then reprogram the
// base and memory size and mix allocations, releases, bad releases, inits and
// the spare code. Typed table rows check as given, others by a map predictor.
// ---------------------------------------------------------------------------
module bitmap_frame_allocator_tb;
  import bfa_pkg::*;

  localparam int FRAME_CAP = 65536;
  localparam int PAGE_SHIFT = 12;
  localparam int COUNT_W = $clog2(FRAME_CAP + 1);
  localparam int TOTAL_REQUESTS = 580;
  localparam int PLAN_ROWS = 30;
  localparam logic [1:0] REQ_SPARE = 2'd3;

  typedef struct packed {
    logic [1:0]         status;
    logic [ADDR_W-1:0]  frame_address;
    logic [COUNT_W-1:0] free_count;
  } frame_reply_t;

  typedef enum logic {ROW_REQUEST, ROW_WRITE} row_kind_t;
  typedef enum logic [1:0] {FLOW_OPEN, FLOW_LIGHT, FLOW_HEAVY, FLOW_BEAT} flow_t;

  typedef struct packed {
    row_kind_t         kind;
    logic              reg_index;
    logic [1:0]        req_type;
    logic [ADDR_W-1:0] value;
    logic              typed;
    frame_reply_t      want;
  } plan_row_t;

  // Corner cases. A write row reprograms a register; a request row carries
  // its free address in value and, where typed is set, its expected result.
  localparam plan_row_t PLAN [PLAN_ROWS] = '{
    '{ROW_REQUEST, CFG_BASE, REQ_ALLOC,  48'h0, 1'b1, '{ST_OOM, 48'h0, 17'd0}},
    '{ROW_REQUEST, CFG_BASE, REQ_FREE,   48'h0, 1'b1, '{ST_INVALID, 48'h0, 17'd0}},
    '{ROW_REQUEST, CFG_BASE, REQ_FREE,   48'hFFFF_FFFF_FFFF, 1'b1,
      '{ST_INVALID, 48'h0, 17'd0}},
    '{ROW_REQUEST, CFG_BASE, REQ_SPARE,  48'hFFFF_FFFF_FFFF, 1'b1, '{ST_OK, 48'h0, 17'd0}},
    '{ROW_REQUEST, CFG_BASE, REQ_INIT,   48'h0, 1'b1, '{ST_OK, 48'h0, 17'd0}},
    '{ROW_WRITE,   CFG_MEM,  REQ_ALLOC,  48'h3064, 1'b0, '0},
    '{ROW_REQUEST, CFG_BASE, REQ_INIT,   48'h0, 1'b1, '{ST_OK, 48'h0, 17'd3}},
    '{ROW_REQUEST, CFG_BASE, REQ_ALLOC,  48'h0, 1'b1, '{ST_OK, 48'h0, 17'd2}},
    '{ROW_REQUEST, CFG_BASE, REQ_ALLOC,  48'h0, 1'b1, '{ST_OK, 48'h1000, 17'd1}},
    '{ROW_REQUEST, CFG_BASE, REQ_ALLOC,  48'h0, 1'b1, '{ST_OK, 48'h2000, 17'd0}},
    '{ROW_REQUEST, CFG_BASE, REQ_ALLOC,  48'h0, 1'b1, '{ST_OOM, 48'h0, 17'd0}},
    '{ROW_REQUEST, CFG_BASE, REQ_FREE,   48'h1005, 1'b1, '{ST_OK, 48'h0, 17'd1}},
    '{ROW_REQUEST, CFG_BASE, REQ_FREE,   48'h1000, 1'b1, '{ST_INVALID, 48'h0, 17'd1}},
    '{ROW_REQUEST, CFG_BASE, REQ_FREE,   48'h3000, 1'b1, '{ST_INVALID, 48'h0, 17'd1}},
    '{ROW_REQUEST, CFG_BASE, REQ_ALLOC,  48'h0, 1'b1, '{ST_OK, 48'h1000, 17'd0}},
    '{ROW_WRITE,   CFG_BASE, REQ_ALLOC,  48'hFFFF_FFFF_E000, 1'b0, '0},
    '{ROW_WRITE,   CFG_MEM,  REQ_ALLOC,  48'hFFFF_FFFF_FFFF, 1'b0, '0},
    // The new base is not live until the next init, so frame 2 is released.
    '{ROW_REQUEST, CFG_BASE, REQ_FREE,   48'h2FFF, 1'b1, '{ST_OK, 48'h0, 17'd1}},
    '{ROW_REQUEST, CFG_BASE, REQ_INIT,   48'h0, 1'b1, '{ST_OK, 48'h0, 17'd65536}},
    '{ROW_REQUEST, CFG_BASE, REQ_ALLOC,  48'h0, 1'b1,
      '{ST_OK, 48'hFFFF_FFFF_E000, 17'd65535}},
    '{ROW_REQUEST, CFG_BASE, REQ_ALLOC,  48'h0, 1'b1,
      '{ST_OK, 48'hFFFF_FFFF_F000, 17'd65534}},
    '{ROW_REQUEST, CFG_BASE, REQ_ALLOC,  48'h0, 1'b1, '{ST_OK, 48'h0, 17'd65533}},
    '{ROW_REQUEST, CFG_BASE, REQ_FREE,   48'h0, 1'b1, '{ST_BELOW, 48'h0, 17'd65533}},
    '{ROW_REQUEST, CFG_BASE, REQ_FREE,   48'hFFFF_FFFF_FFFF, 1'b1,
      '{ST_OK, 48'h0, 17'd65534}},
    '{ROW_REQUEST, CFG_BASE, REQ_FREE,   48'hFFFF_FFFF_F000, 1'b1,
      '{ST_INVALID, 48'h0, 17'd65534}},
    '{ROW_WRITE,   CFG_MEM,  REQ_ALLOC,  48'h0FFF_FFFF, 1'b0, '0},
    '{ROW_WRITE,   CFG_BASE, REQ_ALLOC,  48'hFFFF_FFFF_FFFF, 1'b0, '0},
    '{ROW_REQUEST, CFG_BASE, REQ_INIT,   48'h0, 1'b0, '0},
    '{ROW_REQUEST, CFG_BASE, REQ_ALLOC,  48'h0, 1'b0, '0},
    '{ROW_REQUEST, CFG_BASE, REQ_FREE,   48'hFFFF_FFFF_FFFF, 1'b0, '0}
  };

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic                 cfg_index;
  logic [ADDR_W-1:0]    cfg_wdata;
  logic                 in_valid;
  logic                 in_stall;
  logic [1:0]           in_req_type;
  logic [ADDR_W-1:0]    in_free_address;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [1:0]           out_status;
  logic [ADDR_W-1:0]    out_frame_address;
  logic [COUNT_W-1:0]   out_free_count;

  bitmap_frame_allocator dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_req_type       (in_req_type),
    .in_free_address   (in_free_address),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_status        (out_status),
    .out_frame_address (out_frame_address),
    .out_free_count    (out_free_count)
  );

  // Predictor state: register shadows, the latched init values and the map.
  bit                frame_used [FRAME_CAP];
  logic [ADDR_W-1:0] shadow_base = '0;
  logic [ADDR_W-1:0] shadow_mem = '0;
  logic [ADDR_W-1:0] live_base = '0;
  int unsigned       live_frames = 0;
  int unsigned       frames_free = 0;

  frame_reply_t      replies_due [$];
  frame_reply_t      oldest_reply;
  int unsigned       failures = 0;
  int unsigned       requests_sent = 0;
  int unsigned       burst_left = 0;
  int unsigned       settings_tried = 0;
  int unsigned       inits_done = 0;
  int unsigned       allocs_ok = 0;
  int unsigned       oom_seen = 0;
  int unsigned       frees_ok = 0;
  int unsigned       frees_refused = 0;
  flow_t             flow_mode = FLOW_OPEN;
  int unsigned       flow_left = 0;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #(60_000_000);
    $display("tb: failure");
    $finish;
  end

  function automatic frame_reply_t compute_frame_reply(logic [1:0] kind,
                                                       logic [ADDR_W-1:0] addr);
    frame_reply_t    reply;
    longint unsigned idx;
    int unsigned     i;
    reply = '{ST_OK, '0, '0};
    case (kind)
      REQ_INIT: begin
        idx = longint'(shadow_mem >> PAGE_SHIFT);
        live_frames = (idx > FRAME_CAP) ? FRAME_CAP : int'(idx);
        live_base = shadow_base;
        for (i = 0; i < FRAME_CAP; i++) frame_used[i] = 1'b0;
        frames_free = live_frames;
        inits_done++;
      end
      REQ_ALLOC: begin
        i = 0;
        while (i < live_frames && frame_used[i]) i++;
        if (i < live_frames) begin
          frame_used[i] = 1'b1;
          frames_free--;
          reply.frame_address = live_base + (ADDR_W'(i) << PAGE_SHIFT);
          allocs_ok++;
        end else begin
          reply.status = ST_OOM;
          oom_seen++;
        end
      end
      REQ_FREE: begin
        if (addr < live_base) begin
          reply.status = ST_BELOW;
          frees_refused++;
        end else begin
          idx = longint'(addr - live_base) >> PAGE_SHIFT;
          if (idx >= live_frames || !frame_used[int'(idx)]) begin
            reply.status = ST_INVALID;
            frees_refused++;
          end else begin
            frame_used[int'(idx)] = 1'b0;
            frames_free++;
            frees_ok++;
          end
        end
      end
      default: ;
    endcase
    reply.free_count = COUNT_W'(frames_free);
    return reply;
  endfunction

  // The sender runs in bursts; valid is lowered between bursts unless the gap is empty.
  task automatic send_request(input logic [1:0] kind, input logic [ADDR_W-1:0] addr,
                              output frame_reply_t reply);
    int unsigned pause;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 60)
                                               : $urandom_range(1, 12);
      pause = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 9);
      if (pause != 0) begin
        in_valid <= 1'b0;
        repeat (pause) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_req_type <= kind;
    in_free_address <= addr;
    do @(posedge clk); while (in_stall);
    reply = compute_frame_reply(kind, addr);
    requests_sent++;
  endtask

  // Lowers valid and waits until every outstanding request has answered.
  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (replies_due.size() != 0);
  endtask

  task automatic write_register(input logic index, input logic [ADDR_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= index;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    if (index == CFG_BASE) shadow_base = data;
    else shadow_mem = data;
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (replies_due.size() == 0) begin
        $display("%0t: result with no request outstanding: status %0d address %h",
                 $time, out_status, out_frame_address);
        failures++;
      end else begin
        oldest_reply = replies_due.pop_front();
        if (out_status !== oldest_reply.status) begin
          $display("%0t: status expected %0d actual %0d",
                   $time, oldest_reply.status, out_status);
          failures++;
        end
        if (out_frame_address !== oldest_reply.frame_address) begin
          $display("%0t: frame address expected %h actual %h",
                   $time, oldest_reply.frame_address, out_frame_address);
          failures++;
        end
        if (out_free_count !== oldest_reply.free_count) begin
          $display("%0t: free count expected %0d actual %0d",
                   $time, oldest_reply.free_count, out_free_count);
          failures++;
        end
      end
    end
    if (flow_left == 0) begin
      flow_mode = flow_t'($urandom_range(0, 3));
      flow_left = $urandom_range(40, 300);
    end
    flow_left--;
    case (flow_mode)
      FLOW_OPEN:  out_stall <= 1'b0;
      FLOW_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
      FLOW_HEAVY: out_stall <= ($urandom_range(0, 9) < 7);
      default:    out_stall <= flow_left[2] & flow_left[0];
    endcase
  end

  initial begin : stimulus
    frame_reply_t      got;
    logic [1:0]        kind;
    logic [ADDR_W-1:0] addr;
    logic [ADDR_W-1:0] base;
    logic [ADDR_W-1:0] mem;
    logic [ADDR_W-1:0] held_frames [$];
    int unsigned       pick;
    int unsigned       slot;
    int unsigned       span;
    bit                open_with_init;

    rst_n <= 1'b0;
    cfg_we <= 1'b0;
    cfg_index <= CFG_BASE;
    cfg_wdata <= '0;
    in_valid <= 1'b0;
    in_req_type <= REQ_ALLOC;
    in_free_address <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int r = 0; r < PLAN_ROWS; r++) begin
      if (PLAN[r].kind == ROW_WRITE) begin
        settle();
        write_register(PLAN[r].reg_index, PLAN[r].value);
      end else begin
        send_request(PLAN[r].req_type, PLAN[r].value, got);
        replies_due.push_back(PLAN[r].typed ? PLAN[r].want : got);
      end
    end

    // Random phases: each reprograms the registers while idle and then runs a
    // sequence that mostly allocates and releases frames it holds.
    while (requests_sent < TOTAL_REQUESTS) begin
      settle();
      case ($urandom_range(0, 9))
        0:       base = '0;
        1:       base = '1;
        2, 3:    base = 48'hFFFF_FFF0_0000 | (ADDR_W'($urandom) & 48'hF_F000);
        default: base = ADDR_W'({$urandom, $urandom});
      endcase
      case ($urandom_range(0, 19))
        0:             mem = '0;
        1:             mem = '1;
        2:             mem = 48'h1000_0000;
        3:             mem = 48'h0FFF_FFFF;
        4:             mem = ADDR_W'({$urandom, $urandom});
        5, 6, 7, 8, 9: mem = (ADDR_W'($urandom_range(65, 400)) << PAGE_SHIFT) |
                             ADDR_W'($urandom_range(0, 4095));
        default:       mem = (ADDR_W'($urandom_range(1, 64)) << PAGE_SHIFT) |
                             ADDR_W'($urandom_range(0, 4095));
      endcase
      if ($urandom_range(0, 4) != 0) write_register(CFG_BASE, base);
      if ($urandom_range(0, 4) != 0) write_register(CFG_MEM, mem);
      settings_tried++;
      open_with_init = ($urandom_range(0, 6) != 0);
      span = $urandom_range(20, 50);
      for (int j = 0; j < span; j++) begin
        pick = $urandom_range(0, 99);
        addr = ADDR_W'({$urandom, $urandom});
        if (j == 0 && open_with_init) begin
          kind = REQ_INIT;
        end else if (pick < 45) begin
          kind = REQ_ALLOC;
        end else if (pick < 75 && held_frames.size() != 0) begin
          slot = $urandom_range(0, held_frames.size() - 1);
          kind = REQ_FREE;
          addr = held_frames[slot] + ADDR_W'($urandom_range(0, 4095));
          held_frames.delete(slot);
        end else if (pick < 88) begin
          kind = REQ_FREE;
          case ($urandom_range(0, 3))
            0: ;
            1: addr = live_base - ADDR_W'($urandom_range(1, 1 << 20));
            2: addr = live_base +
                      (ADDR_W'(live_frames + $urandom_range(0, 5)) << PAGE_SHIFT);
            default: addr = live_base +
                            (ADDR_W'($urandom_range(0, live_frames)) << PAGE_SHIFT);
          endcase
        end else if (pick < 94) begin
          kind = REQ_INIT;
        end else begin
          kind = REQ_SPARE;
        end
        send_request(kind, addr, got);
        replies_due.push_back(got);
        if (kind == REQ_INIT) held_frames.delete();
        else if (kind == REQ_ALLOC && got.status == ST_OK)
          held_frames.push_back(got.frame_address);
      end
    end

    settle();
    repeat (20) @(posedge clk);
    $display("Run covered %0d requests over %0d register settings and %0d inits.",
             requests_sent, settings_tried, inits_done);
    $display("Frames handed out %0d, out of memory %0d, released %0d, refused %0d.",
             allocs_ok, oom_seen, frees_ok, frees_refused);
    if (failures == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

>>> files.f
design/bfa_pkg.sv
design/bfa_map.sv
design/bfa_engine.sv
design/bitmap_frame_allocator.sv
tb/bitmap_frame_allocator_tb.sv
